@@ sv/bus_breakpoint_matcher_unit_macros.svh @@
// Assertion macros shared by the breakpoint matcher RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef BUS_BREAKPOINT_MATCHER_UNIT_MACROS_SVH
`define BUS_BREAKPOINT_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define BBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define BBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bbm_pkg.sv @@
// Types and constants of the breakpoint matcher.
// No dependencies; used by the interfaces and the top level.
package bbm_pkg;

  // Entry registers that exist, and how many of them are compared
  localparam int NUM_REGS    = 4;
  localparam int ENTRIES     = 4;
  localparam int CMP_ENTRIES = (ENTRIES < NUM_REGS) ? ENTRIES : NUM_REGS;
  localparam int ENT_IDX_W   = 2;

  // Configuration port geometry: 64-bit registers at 8-byte spacing
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;
  localparam int ENTRY_W     = 37;

  localparam logic [REG_IDX_W-1:0] REG_SINGLE_STEP = REG_IDX_W'(NUM_REGS);

  // Field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 24;
  localparam int DATA_W  = 8;
  localparam int CAUSE_W = 2;
  localparam int COUNT_W = 32;

  // Bus operation and entry kind codes
  localparam logic [OP_W-1:0] OP_FETCH = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STORE = 2'd2;

  // Stop causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_STEP = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_HIT  = 2'd2;

  // Packed breakpoint entry, LSB first: enable, kind, cpu, address, check, data
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              check;
    logic [ADDR_W-1:0] addr;
    logic              cpu;
    logic [OP_W-1:0]   kind;
    logic              en;
  } bp_entry_t;

endpackage

@@ sv/bbm_in_if.sv @@
// Bus event channel into the breakpoint matcher.
// Depends on bbm_pkg for field widths.
interface bbm_in_if import bbm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] bus_data;

  modport source (output valid, operation, address, bus_data, input ready);
  modport sink   (input valid, operation, address, bus_data, output ready);
endinterface

@@ sv/bbm_out_if.sv @@
// Result channel out of the breakpoint matcher.
// Depends on bbm_pkg for field widths.
interface bbm_out_if import bbm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  stop;
  logic [CAUSE_W-1:0]    cause;
  logic [ENT_IDX_W-1:0]  hit_index;
  logic [COUNT_W-1:0]    hit_count;

  modport source (output valid, stop, cause, hit_index, hit_count, input ready);
  modport sink   (input valid, stop, cause, hit_index, hit_count, output ready);
endinterface

@@ sv/bus_breakpoint_matcher_unit.sv @@
// Breakpoint matcher top level: APB register file, compare stage, result stage.
// Depends on bbm_pkg, bbm_in_if, bbm_out_if and the assertion macro header.
//
// Usage:
//   in_ch carries one CPU bus event per transfer (fetch, read or write with
//   address and data byte). out_ch returns exactly one result per event:
//   stop, cause, winning entry index and that entry's updated hit counter.
//   The APB port holds four breakpoint entries (byte addresses 0, 8, 16, 24)
//   and the single-step flag (address 32); pready is always high.
//   An event taken on in_ch is held in the input register and then enters
//   the result register once that register is empty or being taken.
//   Throughput: one event per cycle unless the receiver stalls; the compare
//   stage and the counter update both sit between input and result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more event, after which in_ch.ready drops.
//   Synchronous reset clears entries, single step, all hit counters and
//   both pipeline stages; no clearing pass is needed.
//   Entries must be written only while no event is in flight; the block does not enforce it.
`include "bus_breakpoint_matcher_unit_macros.svh"

module bus_breakpoint_matcher_unit
  import bbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bbm_in_if.sink                in_ch,
  bbm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers
  bp_entry_t entry_r [NUM_REGS];
  logic      single_step_r;

  // Input stage
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [DATA_W-1:0] s1_data_r;

  // Result stage
  logic                 out_valid_r;
  logic                 out_stop_r;
  logic [CAUSE_W-1:0]   out_cause_r;
  logic [ENT_IDX_W-1:0] out_idx_r;
  logic [COUNT_W-1:0]   out_count_r;

  // Counters and event history
  logic [COUNT_W-1:0]   hit_cnt_r [NUM_REGS];
  logic [ENT_IDX_W-1:0] last_hit_r;
  logic [CAUSE_W-1:0]   last_cause_r;

  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;
  logic                   advance;
  logic                   s1_xfer;
  logic [CMP_ENTRIES-1:0] match;
  logic                   op_ok;
  logic                   hit_any;
  logic [ENT_IDX_W-1:0]   hit_sel;
  logic [COUNT_W-1:0]     cnt_cur;
  logic [COUNT_W-1:0]     cnt_nxt;
  logic [CAUSE_W-1:0]     cause_nxt;

  // ---------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        entry_r[i] <= '0;
      end
      single_step_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_idx < REG_SINGLE_STEP) begin
        entry_r[cfg_idx[ENT_IDX_W-1:0]] <= pwdata[ENTRY_W-1:0];
      end else if (cfg_idx == REG_SINGLE_STEP) begin
        single_step_r <= pwdata[0];
      end
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    if (cfg_idx < REG_SINGLE_STEP) begin
      prdata = CFG_DATA_W'(entry_r[cfg_idx[ENT_IDX_W-1:0]]);
    end else if (cfg_idx == REG_SINGLE_STEP) begin
      prdata = CFG_DATA_W'(single_step_r);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: result register frees when empty or taken
  // ---------------------------------------------------------------------
  assign advance     = !out_valid_r || out_ch.ready;
  assign s1_xfer     = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r   <= in_ch.operation;
      s1_addr_r <= in_ch.address;
      s1_data_r <= in_ch.bus_data;
    end
  end

  // ---------------------------------------------------------------------
  // Compare every entry against the held event
  // ---------------------------------------------------------------------
  assign op_ok = s1_op_r inside {OP_FETCH, OP_READ, OP_STORE};

  always_comb begin
    for (int i = 0; i < CMP_ENTRIES; i++) begin
      match[i] = op_ok && entry_r[i].en && entry_r[i].cpu &&
                 (entry_r[i].kind == s1_op_r) && (entry_r[i].addr == s1_addr_r) &&
                 ((s1_op_r == OP_FETCH) || !entry_r[i].check ||
                  (entry_r[i].data == s1_data_r));
    end
  end

  // Lowest-numbered match wins
  always_comb begin
    hit_any = 1'b0;
    hit_sel = '0;
    for (int i = CMP_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_sel = ENT_IDX_W'(i);
      end
    end
  end

  // Saturating increment of the winner's counter
  assign cnt_cur = hit_cnt_r[hit_sel];
  assign cnt_nxt = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);

  always_comb begin
    if (hit_any) begin
      cause_nxt = CAUSE_HIT;
    end else if (single_step_r && (s1_op_r == OP_FETCH)) begin
      cause_nxt = CAUSE_STEP;
    end else begin
      cause_nxt = CAUSE_NONE;
    end
  end

  // ---------------------------------------------------------------------
  // Counters and history, updated as the event enters the result stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        hit_cnt_r[i] <= '0;
      end
      last_hit_r   <= '0;
      last_cause_r <= CAUSE_NONE;
    end else if (s1_xfer) begin
      if (hit_any) begin
        hit_cnt_r[hit_sel] <= cnt_nxt;
        last_hit_r         <= hit_sel;
      end
      if (cause_nxt != CAUSE_NONE) begin
        last_cause_r <= cause_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_xfer) begin
      out_stop_r  <= (cause_nxt != CAUSE_NONE);
      out_cause_r <= cause_nxt;
      out_idx_r   <= hit_any ? hit_sel : '0;
      out_count_r <= hit_any ? cnt_nxt : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.stop      = out_stop_r;
  assign out_ch.cause     = out_cause_r;
  assign out_ch.hit_index = out_idx_r;
  assign out_ch.hit_count = out_count_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BBM_ASSERT_IMP(a_stop_cause, out_valid_r, out_stop_r == (out_cause_r != CAUSE_NONE), "stop disagrees with cause")
  `BBM_ASSERT_IMP(a_hit_count_nz, out_valid_r && (out_cause_r == CAUSE_HIT), out_count_r != '0, "breakpoint hit with zero count")
  `BBM_ASSERT_IMP(a_nohit_zero, out_valid_r && (out_cause_r != CAUSE_HIT), (out_idx_r == '0) && (out_count_r == '0), "index or count set without a hit")
  `BBM_ASSERT_NXT(a_counter_track, s1_xfer && hit_any, (hit_cnt_r[out_idx_r] == out_count_r) && (last_hit_r == out_idx_r), "counter or last hit out of step with result")
  `BBM_ASSERT_NXT(a_last_cause, s1_xfer, (out_cause_r == CAUSE_NONE) || (last_cause_r == out_cause_r), "last cause not updated on stop")

endmodule
